FILE: hdl/ert_pkg.sv
// Shared types, codes and constants of the echo request tracker.
package ert_pkg;

  // Default number of table entries.
  localparam int TABLE_DEPTH_DEFAULT = 64;

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int SEQ_W    = 16;
  localparam int IDENT_W  = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int FLAGS_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SEND   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPORT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [IDENT_W-1:0] OWN_IDENT_RESET = 16'd0;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET   = 32'd2000000;
  localparam logic [TIME_W-1:0]  THRESHOLD_RESET = 32'd0;

  // Bit positions within the entry flags.
  localparam int FLAG_REPLIED = 0;
  localparam int FLAG_LOST    = 1;
  localparam int FLAG_OVER    = 2;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  sent_time;
    logic [FLAGS_W-1:0] flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/ert_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ert_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/echo_request_tracker_top.sv
// Top level of the echo request tracker: control sequencer around the entry table.
//
// The tracker keeps outstanding echo requests in one table memory, oldest first, and
// handles one transaction at a time. An accepted item passes through the execute
// state, where a send, clear or unknown item is carried out, and the result state,
// which loads the result into the output register once that register is free. A
// reply, tick or report instead walks the occupied entries between the two states,
// through the single read port of the table memory, one entry per cycle (a reply
// stops early at its first match, and a reply with a foreign identifier does not
// walk). A new item is accepted only after the result of the last one has been
// loaded. A tick writes updated flags back to each pending entry just after reading
// it, and a reply writes back the one entry it resolves. The table needs no clearing
// after reset: only entries below the fill count are ever used. Configuration
// registers are written through a plain write port with no handshake and should be
// changed only while the block is idle.
module echo_request_tracker_top #(
  parameter int TABLE_DEPTH = ert_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_wr_en,
  input  logic [ert_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ert_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ert_pkg::KIND_W-1:0]      kind,
  input  logic [ert_pkg::SEQ_W-1:0]       seq_num,
  input  logic [ert_pkg::IDENT_W-1:0]     reply_ident,
  input  logic [ert_pkg::TIME_W-1:0]      now_us,
  // Output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ert_pkg::STATUS_W-1:0]    status,
  output logic [ert_pkg::TIME_W-1:0]      rtt_us,
  output logic [ert_pkg::COUNT_W-1:0]     newly_lost,
  output logic [ert_pkg::COUNT_W-1:0]     resolved_count,
  output logic [ert_pkg::COUNT_W-1:0]     replied_count,
  output logic [ert_pkg::COUNT_W-1:0]     lost_count,
  output logic [ert_pkg::COUNT_W-1:0]     over_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = ert_pkg::COUNT_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state, state_next;

  // Configuration registers.
  logic [ert_pkg::IDENT_W-1:0] own_ident;
  logic [ert_pkg::TIME_W-1:0]  timeout_us;
  logic [ert_pkg::TIME_W-1:0]  threshold_us;

  // Table occupancy and walk position.
  logic [FW-1:0] fill_count, fill_count_next;
  logic [AW-1:0] cur_idx, cur_idx_next;

  // Captured input transaction.
  logic [ert_pkg::KIND_W-1:0]  it_kind;
  logic [ert_pkg::SEQ_W-1:0]   it_seq;
  logic [ert_pkg::IDENT_W-1:0] it_ident;
  logic [ert_pkg::TIME_W-1:0]  it_now;

  // Result under construction.
  logic [ert_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [ert_pkg::TIME_W-1:0]   res_rtt, res_rtt_next;
  logic [CW-1:0] res_newly, res_newly_next;
  logic [CW-1:0] res_resolved, res_resolved_next;
  logic [CW-1:0] res_replied, res_replied_next;
  logic [CW-1:0] res_lost, res_lost_next;
  logic [CW-1:0] res_over, res_over_next;

  // Output register control.
  logic out_valid_next;
  logic out_load;

  // Table memory ports.
  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  ert_pkg::entry_t ram_wr_data;
  logic [AW-1:0]   ram_rd_addr;
  ert_pkg::entry_t ram_rd_data;

  // Per-entry evaluation during a walk.
  logic                       entry_pending;
  logic [ert_pkg::TIME_W-1:0] entry_elapsed;
  logic                       entry_last;
  logic                       entry_lost;
  logic                       entry_over;
  logic                       entry_match;

  ert_ram #(
    .WIDTH (ert_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready = (state == ST_IDLE);

  // Evaluation of the entry that the memory presents this cycle.
  assign entry_pending = !ram_rd_data.flags[ert_pkg::FLAG_REPLIED] &&
                         !ram_rd_data.flags[ert_pkg::FLAG_LOST];
  assign entry_elapsed = it_now - ram_rd_data.sent_time;
  assign entry_last    = (FW'(cur_idx) + FW'(1)) == fill_count;
  assign entry_lost    = entry_elapsed > timeout_us;
  assign entry_over    = (threshold_us != '0) && (entry_elapsed > threshold_us);
  assign entry_match   = entry_pending && (ram_rd_data.seq == it_seq);

  // Sequencer and table access.
  always_comb begin
    state_next        = state;
    fill_count_next   = fill_count;
    cur_idx_next      = cur_idx;
    res_status_next   = res_status;
    res_rtt_next      = res_rtt;
    res_newly_next    = res_newly;
    res_resolved_next = res_resolved;
    res_replied_next  = res_replied;
    res_lost_next     = res_lost;
    res_over_next     = res_over;
    ram_wr_en         = 1'b0;
    ram_wr_addr       = cur_idx;
    ram_wr_data       = ram_rd_data;
    ram_rd_addr       = cur_idx + AW'(1);
    out_load          = 1'b0;
    out_valid_next    = out_valid && !out_ready;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_status_next   = ert_pkg::STATUS_OK;
        res_rtt_next      = '0;
        res_newly_next    = '0;
        res_resolved_next = '0;
        res_replied_next  = '0;
        res_lost_next     = '0;
        res_over_next     = '0;
        cur_idx_next      = '0;
        ram_rd_addr       = '0;
        state_next        = ST_RESULT;
        case (it_kind)
          ert_pkg::KIND_SEND: begin
            if (fill_count == FW'(TABLE_DEPTH)) begin
              res_status_next = ert_pkg::STATUS_FULL;
            end else begin
              ram_wr_en             = 1'b1;
              ram_wr_addr           = fill_count[AW-1:0];
              ram_wr_data.seq       = it_seq;
              ram_wr_data.sent_time = it_now;
              ram_wr_data.flags     = '0;
              fill_count_next       = fill_count + FW'(1);
            end
          end
          ert_pkg::KIND_REPLY: begin
            res_status_next = ert_pkg::STATUS_IGNORED;
            if ((it_ident == own_ident) && (fill_count != '0)) begin
              state_next = ST_WALK;
            end
          end
          ert_pkg::KIND_TICK, ert_pkg::KIND_REPORT: begin
            if (fill_count != '0) begin
              state_next = ST_WALK;
            end
          end
          ert_pkg::KIND_CLEAR: begin
            fill_count_next = '0;
          end
          default: begin
            res_status_next = ert_pkg::STATUS_OK;
          end
        endcase
      end

      ST_WALK: begin
        cur_idx_next = cur_idx + AW'(1);
        if (entry_last) begin
          state_next = ST_RESULT;
        end
        case (it_kind)
          ert_pkg::KIND_REPLY: begin
            // The first pending entry with the same sequence number is the oldest.
            if (entry_match) begin
              ram_wr_en                                = 1'b1;
              ram_wr_data.flags[ert_pkg::FLAG_REPLIED] = 1'b1;
              res_status_next                          = ert_pkg::STATUS_OK;
              res_rtt_next                             = entry_elapsed;
              state_next                               = ST_RESULT;
            end
          end
          ert_pkg::KIND_TICK: begin
            // Pending entries may become lost and over threshold in the same tick.
            if (entry_pending) begin
              ram_wr_en = 1'b1;
              if (entry_lost) begin
                ram_wr_data.flags[ert_pkg::FLAG_LOST] = 1'b1;
                res_newly_next = res_newly + CW'(1);
              end
              if (entry_over) begin
                ram_wr_data.flags[ert_pkg::FLAG_OVER] = 1'b1;
              end
            end
          end
          ert_pkg::KIND_REPORT: begin
            if (!entry_pending) begin
              res_resolved_next = res_resolved + CW'(1);
            end
            if (ram_rd_data.flags[ert_pkg::FLAG_REPLIED]) begin
              res_replied_next = res_replied + CW'(1);
            end
            if (ram_rd_data.flags[ert_pkg::FLAG_LOST]) begin
              res_lost_next = res_lost + CW'(1);
            end else if (ram_rd_data.flags[ert_pkg::FLAG_OVER]) begin
              res_over_next = res_over + CW'(1);
            end
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      ST_RESULT: begin
        // Hand the result over once the output register is free.
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Configuration registers; writes to indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ident    <= ert_pkg::OWN_IDENT_RESET;
      timeout_us   <= ert_pkg::TIMEOUT_RESET;
      threshold_us <= ert_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ert_pkg::CFG_OWN_IDENT: own_ident    <= cfg_data[ert_pkg::IDENT_W-1:0];
        ert_pkg::CFG_TIMEOUT:   timeout_us   <= cfg_data[ert_pkg::TIME_W-1:0];
        ert_pkg::CFG_THRESHOLD: threshold_us <= cfg_data[ert_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Captured transaction, walk position and result under construction.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_kind  <= kind;
      it_seq   <= seq_num;
      it_ident <= reply_ident;
      it_now   <= now_us;
    end
    cur_idx      <= cur_idx_next;
    res_status   <= res_status_next;
    res_rtt      <= res_rtt_next;
    res_newly    <= res_newly_next;
    res_resolved <= res_resolved_next;
    res_replied  <= res_replied_next;
    res_lost     <= res_lost_next;
    res_over     <= res_over_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= res_status;
      rtt_us         <= res_rtt;
      newly_lost     <= res_newly;
      resolved_count <= res_resolved;
      replied_count  <= res_replied;
      lost_count     <= res_lost;
      over_count     <= res_over;
    end
  end

endmodule

FILE: test/tb.sv
// Self-checking testbench for the echo request tracker top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ert_pkg::TABLE_DEPTH_DEFAULT;
  // Kinds above the clear code are not defined and must leave the table alone.
  localparam logic [ert_pkg::KIND_W-1:0] KIND_UNDEF_FIRST = 3'd5;
  localparam int UNDEF_KINDS = 3;

  // One request transaction as presented on the input channel.
  typedef struct packed {
    logic [ert_pkg::KIND_W-1:0]  op;
    logic [ert_pkg::SEQ_W-1:0]   seq_no;
    logic [ert_pkg::IDENT_W-1:0] ident;
    logic [ert_pkg::TIME_W-1:0]  stamp;
  } req_t;

  // One result transaction as returned on the output channel.
  typedef struct packed {
    logic [ert_pkg::STATUS_W-1:0] status;
    logic [ert_pkg::TIME_W-1:0]   rtt;
    logic [ert_pkg::COUNT_W-1:0]  newly;
    logic [ert_pkg::COUNT_W-1:0]  resolved;
    logic [ert_pkg::COUNT_W-1:0]  replied;
    logic [ert_pkg::COUNT_W-1:0]  lost;
    logic [ert_pkg::COUNT_W-1:0]  over;
  } res_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [ert_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ert_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [ert_pkg::KIND_W-1:0]     kind = '0;
  logic [ert_pkg::SEQ_W-1:0]      seq_num = '0;
  logic [ert_pkg::IDENT_W-1:0]    reply_ident = '0;
  logic [ert_pkg::TIME_W-1:0]     now_us = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [ert_pkg::STATUS_W-1:0]   status;
  logic [ert_pkg::TIME_W-1:0]     rtt_us;
  logic [ert_pkg::COUNT_W-1:0]    newly_lost;
  logic [ert_pkg::COUNT_W-1:0]    resolved_count;
  logic [ert_pkg::COUNT_W-1:0]    replied_count;
  logic [ert_pkg::COUNT_W-1:0]    lost_count;
  logic [ert_pkg::COUNT_W-1:0]    over_count;

  echo_request_tracker_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .seq_num(seq_num), .reply_ident(reply_ident), .now_us(now_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .rtt_us(rtt_us), .newly_lost(newly_lost),
    .resolved_count(resolved_count), .replied_count(replied_count),
    .lost_count(lost_count), .over_count(over_count)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the tracker's table and registers.
  logic [ert_pkg::SEQ_W-1:0]   tbl_seq [DEPTH];
  logic [ert_pkg::TIME_W-1:0]  tbl_sent [DEPTH];
  logic [ert_pkg::FLAGS_W-1:0] tbl_flags [DEPTH];
  int unsigned                 tbl_fill = 0;
  logic [ert_pkg::IDENT_W-1:0] cfg_own = ert_pkg::OWN_IDENT_RESET;
  logic [ert_pkg::TIME_W-1:0]  cfg_timeout = ert_pkg::TIMEOUT_RESET;
  logic [ert_pkg::TIME_W-1:0]  cfg_threshold = ert_pkg::THRESHOLD_RESET;

  req_t request_queue[$];
  res_t awaited_results[$];
  req_t cur_req = '0;
  bit   calm = 1'b0;
  int   fault_count = 0;

  // Stimulus side bookkeeping: running time and sequence numbers sent since a clear.
  logic [ert_pkg::TIME_W-1:0] gen_now;
  logic [ert_pkg::SEQ_W-1:0]  gen_seqs[$];

  // Applies one request to the shadow table and returns the result it should give.
  function automatic res_t track_item(req_t it);
    res_t r;
    bit hit;
    logic [ert_pkg::TIME_W-1:0] elapsed;
    r = '0;
    hit = 1'b0;
    case (it.op)
      ert_pkg::KIND_SEND: begin
        if (tbl_fill >= DEPTH) begin
          r.status = ert_pkg::STATUS_FULL;
        end else begin
          tbl_seq[tbl_fill] = it.seq_no;
          tbl_sent[tbl_fill] = it.stamp;
          tbl_flags[tbl_fill] = '0;
          tbl_fill++;
        end
      end
      ert_pkg::KIND_REPLY: begin
        r.status = ert_pkg::STATUS_IGNORED;
        if (it.ident == cfg_own) begin
          // Oldest pending entry with the same sequence number wins.
          for (int i = 0; i < tbl_fill; i++) begin
            if (!hit && tbl_seq[i] == it.seq_no &&
                !tbl_flags[i][ert_pkg::FLAG_REPLIED] &&
                !tbl_flags[i][ert_pkg::FLAG_LOST]) begin
              hit = 1'b1;
              tbl_flags[i][ert_pkg::FLAG_REPLIED] = 1'b1;
              r.rtt = it.stamp - tbl_sent[i];
              r.status = ert_pkg::STATUS_OK;
            end
          end
        end
      end
      ert_pkg::KIND_TICK: begin
        // Loss and threshold are both judged on the same elapsed time.
        for (int i = 0; i < tbl_fill; i++) begin
          if (!tbl_flags[i][ert_pkg::FLAG_REPLIED] &&
              !tbl_flags[i][ert_pkg::FLAG_LOST]) begin
            elapsed = it.stamp - tbl_sent[i];
            if (elapsed > cfg_timeout) begin
              tbl_flags[i][ert_pkg::FLAG_LOST] = 1'b1;
              r.newly++;
            end
            if (cfg_threshold != 0 && elapsed > cfg_threshold)
              tbl_flags[i][ert_pkg::FLAG_OVER] = 1'b1;
          end
        end
      end
      ert_pkg::KIND_REPORT: begin
        for (int i = 0; i < tbl_fill; i++) begin
          if (tbl_flags[i][ert_pkg::FLAG_REPLIED] || tbl_flags[i][ert_pkg::FLAG_LOST])
            r.resolved++;
          if (tbl_flags[i][ert_pkg::FLAG_REPLIED]) r.replied++;
          if (tbl_flags[i][ert_pkg::FLAG_LOST]) r.lost++;
          else if (tbl_flags[i][ert_pkg::FLAG_OVER]) r.over++;
        end
      end
      ert_pkg::KIND_CLEAR: tbl_fill = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit take_pause();
    return !calm && ($urandom_range(99) < 8);
  endfunction

  // Request driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin
    req_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(track_item(cur_req));
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && !take_pause()) begin
          next_req = request_queue.pop_front();
          cur_req <= next_req;
          kind <= next_req.op;
          seq_num <= next_req.seq_no;
          reply_ident <= next_req.ident;
          now_us <= next_req.stamp;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each accepted result must match the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, rtt_us, newly_lost, resolved_count, replied_count,
               lost_count, over_count};
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with none expected: status %0d rtt %h", $realtime,
                     got.status, got.rtt);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected st %0d rtt %h new %0d res %0d rep %0d lost %0d over %0d",
                       want.status, want.rtt, want.newly, want.resolved,
                       want.replied, want.lost, want.over);
              $display("  actual   st %0d rtt %h new %0d res %0d rep %0d lost %0d over %0d",
                       got.status, got.rtt, got.newly, got.resolved,
                       got.replied, got.lost, got.over);
            end
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  task automatic push_req(input logic [ert_pkg::KIND_W-1:0] op,
                          input logic [ert_pkg::SEQ_W-1:0] sq,
                          input logic [ert_pkg::IDENT_W-1:0] id,
                          input logic [ert_pkg::TIME_W-1:0] at);
    request_queue.push_back('{op: op, seq_no: sq, ident: id, stamp: at});
  endtask

  // Writes all three registers back to back; only called while the tracker is idle.
  task automatic set_config(input logic [ert_pkg::IDENT_W-1:0] own,
                            input logic [ert_pkg::TIME_W-1:0] tmo,
                            input logic [ert_pkg::TIME_W-1:0] thr);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= ert_pkg::CFG_OWN_IDENT;
    cfg_data <= ert_pkg::CFG_DATA_W'(own);
    @(posedge clk);
    cfg_index <= ert_pkg::CFG_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= ert_pkg::CFG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_own = own;
    cfg_timeout = tmo;
    cfg_threshold = thr;
  endtask

  // Waits until every queued transaction has gone in and its result has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  // Mostly well-formed traffic: sends, replies to earlier sends, ticks and reports,
  // with foreign or unmatched replies, stray times, clears and undefined kinds mixed in.
  task automatic queue_random(input int count, input int unsigned step);
    int unsigned pick;
    logic [ert_pkg::SEQ_W-1:0] sq;
    logic [ert_pkg::IDENT_W-1:0] id;
    repeat (count) begin
      pick = $urandom_range(99);
      gen_now += $urandom_range(step);
      sq = (gen_seqs.size() != 0 && $urandom_range(4) != 0) ?
           gen_seqs[$urandom_range(gen_seqs.size() - 1)] : ert_pkg::SEQ_W'($urandom);
      id = ($urandom_range(9) != 0) ? cfg_own : ert_pkg::IDENT_W'($urandom);
      if (pick < 40) begin
        if ($urandom_range(3) != 0) sq = ert_pkg::SEQ_W'($urandom);
        gen_seqs.push_back(sq);
        push_req(ert_pkg::KIND_SEND, sq, ert_pkg::IDENT_W'($urandom), gen_now);
      end else if (pick < 70) begin
        push_req(ert_pkg::KIND_REPLY, sq, id, gen_now);
      end else if (pick < 84) begin
        push_req(ert_pkg::KIND_TICK, ert_pkg::SEQ_W'($urandom),
                 ert_pkg::IDENT_W'($urandom),
                 ($urandom_range(49) == 0) ? ert_pkg::TIME_W'($urandom) : gen_now);
      end else if (pick < 95) begin
        push_req(ert_pkg::KIND_REPORT, ert_pkg::SEQ_W'($urandom),
                 ert_pkg::IDENT_W'($urandom), ert_pkg::TIME_W'($urandom));
      end else if (pick < 98) begin
        gen_seqs.delete();
        push_req(ert_pkg::KIND_CLEAR, ert_pkg::SEQ_W'($urandom),
                 ert_pkg::IDENT_W'($urandom), ert_pkg::TIME_W'($urandom));
      end else begin
        push_req(KIND_UNDEF_FIRST + ert_pkg::KIND_W'($urandom_range(UNDEF_KINDS - 1)),
                 ert_pkg::SEQ_W'($urandom), ert_pkg::IDENT_W'($urandom),
                 ert_pkg::TIME_W'($urandom));
      end
    end
  endtask

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("** echo_request_tracker_top: FAILED **");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: wrapping times, duplicate sequence numbers, foreign and
    // unmatched replies, loss and threshold in one tick, undefined kinds, clear.
    set_config(16'h0000, ert_pkg::TIMEOUT_RESET, 32'd1000);
    push_req(ert_pkg::KIND_SEND,   16'h0000, 16'hFFFF, 32'hFFFF_FF00);
    push_req(ert_pkg::KIND_SEND,   16'hFFFF, 16'h0000, 32'hFFFF_FF80);
    push_req(ert_pkg::KIND_SEND,   16'h0000, 16'h0000, 32'h0000_0010);
    push_req(ert_pkg::KIND_REPLY,  16'h0000, 16'h0000, 32'h0000_0100);
    push_req(ert_pkg::KIND_REPLY,  16'h0000, 16'hFFFF, 32'h0000_0180);
    push_req(ert_pkg::KIND_REPLY,  16'h1234, 16'h0000, 32'h0000_0200);
    push_req(ert_pkg::KIND_REPLY,  16'h0000, 16'h0000, 32'h0000_0300);
    push_req(ert_pkg::KIND_TICK,   16'h0000, 16'h0000, 32'h0000_0400);
    push_req(ert_pkg::KIND_REPORT, 16'h0000, 16'h0000, 32'h0000_0000);
    push_req(ert_pkg::KIND_TICK,   16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    push_req(ert_pkg::KIND_REPORT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(ert_pkg::KIND_SEND,   16'h8000, 16'h0000, 32'hFFFF_FFFF);
    push_req(ert_pkg::KIND_TICK,   16'h0000, 16'h0000, 32'h0030_0000);
    push_req(ert_pkg::KIND_REPLY,  16'h8000, 16'h0000, 32'h0030_0001);
    for (int j = 0; j < UNDEF_KINDS; j++)
      push_req(KIND_UNDEF_FIRST + ert_pkg::KIND_W'(j), 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(ert_pkg::KIND_REPORT, 16'h0000, 16'h0000, 32'h0000_0000);
    push_req(ert_pkg::KIND_CLEAR,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(ert_pkg::KIND_REPORT, 16'h0000, 16'h0000, 32'h0000_0000);
    push_req(ert_pkg::KIND_REPLY,  16'hFFFF, 16'h0000, 32'h0000_0000);
    push_req(ert_pkg::KIND_SEND,   16'hFFFF, 16'h0000, 32'h0000_0000);
    push_req(ert_pkg::KIND_TICK,   16'h0000, 16'h0000, 32'h0000_0000);
    push_req(ert_pkg::KIND_REPORT, 16'h0000, 16'h0000, 32'h0000_0000);
    wait_idle();

    // Default timeout with a moderate threshold; random identifier.
    gen_now = $urandom;
    set_config(ert_pkg::IDENT_W'($urandom), ert_pkg::TIMEOUT_RESET, 32'd500_000);
    queue_random(70, 200_000);
    wait_idle();

    // Shortest nonzero timeout, threshold that can never be exceeded.
    set_config(16'hFFFF, 32'd1, 32'hFFFF_FFFF);
    queue_random(60, 50);
    wait_idle();

    // Timeout that can never be exceeded, smallest threshold, no idling at all.
    calm = 1'b1;
    set_config(16'h0000, 32'hFFFF_FFFF, 32'd1);
    queue_random(60, 1 << 20);
    wait_idle();
    calm = 1'b0;

    // Fill the table to overflow, then carry on with threshold flagging off.
    set_config(ert_pkg::IDENT_W'($urandom),
               ert_pkg::TIME_W'($urandom_range(5_000_000, 1000)), 32'd0);
    repeat (DEPTH + 2) begin
      gen_now += $urandom_range(1000);
      gen_seqs.push_back(ert_pkg::SEQ_W'($urandom));
      push_req(ert_pkg::KIND_SEND, gen_seqs[$], ert_pkg::IDENT_W'($urandom), gen_now);
    end
    queue_random(80, cfg_timeout / 8);
    wait_idle();

    // Everything random, including the time steps.
    set_config(ert_pkg::IDENT_W'($urandom), ert_pkg::TIME_W'($urandom),
               ert_pkg::TIME_W'($urandom));
    queue_random(40, $urandom_range(32'h4000_0000, 1));
    wait_idle();

    repeat (DEPTH + 8) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0)
      $display("** echo_request_tracker_top: PASSED **");
    else
      $display("** echo_request_tracker_top: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ert_pkg.sv
hdl/ert_ram.sv
hdl/echo_request_tracker_top.sv
test/tb.sv
